[rtl/pma_pkg.sv]
// ----------------------------------------------------------------------------
// pma_pkg
// Shared widths, datapath operation codes and the control/status bundles
// of the paged memory allocator.
// ----------------------------------------------------------------------------
package pma_pkg;

  localparam int OFFSET_BITS = 10;
  localparam int VPAGE_BITS  = 10;
  localparam int FRAME_BITS  = 10;
  localparam int NUM_FRAMES  = 1024;
  localparam int ADDR_BITS   = 20;
  localparam int PID_BITS    = 4;
  localparam int PIDX_BITS   = 3;
  localparam int MAX_PROCS   = 8;
  localparam int SIZE_BITS   = 21;
  localparam int PAGES_BITS  = 12;
  localparam int CNT_BITS    = FRAME_BITS + 1;
  localparam int PMAP_ABITS  = PIDX_BITS + VPAGE_BITS;

  localparam logic [ADDR_BITS-1:0] BREAK_RESET = 20'd1024;

  localparam logic [1:0] ACT_ALLOC = 2'd0;
  localparam logic [1:0] ACT_FREE  = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;
  localparam logic [1:0] ACT_WRITE = 2'd3;

  localparam logic [3:0] OP_NONE      = 4'd0;
  localparam logic [3:0] OP_CLEAR     = 4'd1;
  localparam logic [3:0] OP_LATCH     = 4'd2;
  localparam logic [3:0] OP_PMAP_RD   = 4'd3;
  localparam logic [3:0] OP_FRAME_RD  = 4'd4;
  localparam logic [3:0] OP_SCAN_INIT = 4'd5;
  localparam logic [3:0] OP_SCAN      = 4'd6;
  localparam logic [3:0] OP_ALLOC_END = 4'd7;
  localparam logic [3:0] OP_WALK      = 4'd8;
  localparam logic [3:0] OP_RAM_RD    = 4'd9;
  localparam logic [3:0] OP_RAM_WR    = 4'd10;
  localparam logic [3:0] OP_RESULT    = 4'd11;

  typedef struct packed {
    logic [3:0] op;
    logic       ok;
  } cmd_t;

  typedef struct packed {
    logic       clr_last;
    logic [1:0] action;
    logic       pid_ok;
    logic       alloc_ok;
    logic       map_ok;
    logic       own_ok;
    logic       pos_zero;
    logic       next_last;
    logic       scan_full;
    logic       out_busy;
  } sts_t;

endpackage

[rtl/pma_ctrl.sv]
// ----------------------------------------------------------------------------
// pma_ctrl
// Sequencer of the allocator: clearing pass, request decode, frame scan,
// chain walk and result hand-off.
// ----------------------------------------------------------------------------
module pma_ctrl import pma_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_DECODE = 4'd2;
  localparam logic [3:0] S_FRAME  = 4'd3;
  localparam logic [3:0] S_CHECK  = 4'd4;
  localparam logic [3:0] S_SCAN   = 4'd5;
  localparam logic [3:0] S_AEND   = 4'd6;
  localparam logic [3:0] S_WALK   = 4'd7;
  localparam logic [3:0] S_WALKW  = 4'd8;
  localparam logic [3:0] S_RESULT = 4'd9;

  logic [3:0] state_q, state_d;
  logic       ok_q, ok_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d   = state_q;
    ok_d      = ok_q;
    cmd_o.op  = OP_NONE;
    cmd_o.ok  = ok_q;
    case (state_q)
      S_CLEAR: begin
        cmd_o.op = OP_CLEAR;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LATCH;
          state_d  = S_DECODE;
        end
      end
      S_DECODE: begin
        ok_d = 1'b0;
        if (!sts_i.pid_ok) begin
          state_d = S_RESULT;
        end else if (sts_i.action == ACT_ALLOC) begin
          if (sts_i.alloc_ok) begin
            cmd_o.op = OP_SCAN_INIT;
            state_d  = S_SCAN;
          end else begin
            state_d = S_RESULT;
          end
        end else begin
          cmd_o.op = OP_PMAP_RD;
          state_d  = S_FRAME;
        end
      end
      S_FRAME: begin
        cmd_o.op = OP_FRAME_RD;
        state_d  = S_CHECK;
      end
      S_CHECK: begin
        state_d = S_RESULT;
        if (sts_i.map_ok && sts_i.own_ok) begin
          case (sts_i.action)
            ACT_FREE: begin
              if (sts_i.pos_zero) begin
                ok_d    = 1'b1;
                state_d = S_WALK;
              end
            end
            ACT_READ: begin
              ok_d     = 1'b1;
              cmd_o.op = OP_RAM_RD;
            end
            ACT_WRITE: begin
              ok_d     = 1'b1;
              cmd_o.op = OP_RAM_WR;
            end
            default: ok_d = 1'b0;
          endcase
        end
      end
      S_SCAN: begin
        // advance one frame a cycle until enough free frames are taken
        cmd_o.op = OP_SCAN;
        if (sts_i.scan_full) state_d = S_AEND;
      end
      S_AEND: begin
        cmd_o.op = OP_ALLOC_END;
        ok_d     = 1'b1;
        state_d  = S_RESULT;
      end
      S_WALK: begin
        cmd_o.op = OP_WALK;
        state_d  = sts_i.next_last ? S_RESULT : S_WALKW;
      end
      S_WALKW: begin
        state_d = S_WALK;
      end
      S_RESULT: begin
        if (!sts_i.out_busy) begin
          cmd_o.op = OP_RESULT;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      ok_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ok_q    <= ok_d;
    end
  end

endmodule

[rtl/pma_dp.sv]
// ----------------------------------------------------------------------------
// pma_dp
// Datapath: request registers, frame tables, page maps, byte memory,
// break pointers, free frame count and the result register.
// ----------------------------------------------------------------------------
module pma_dp import pma_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  input  logic [1:0]           action_i,
  input  logic [PID_BITS-1:0]  process_id_i,
  input  logic [SIZE_BITS-1:0] alloc_size_i,
  input  logic [ADDR_BITS-1:0] virtual_address_i,
  input  logic [7:0]           write_data_i,
  input  logic                 cfg_we_i,
  input  logic [ADDR_BITS-1:0] cfg_data_i,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output logic                 status_o,
  output logic [ADDR_BITS-1:0] region_address_o,
  output logic [7:0]           read_data_o
);

  // memories
  logic [PID_BITS-1:0]     own_mem  [NUM_FRAMES];
  logic [FRAME_BITS-1:0]   pos_mem  [NUM_FRAMES];
  logic [FRAME_BITS:0]     next_mem [NUM_FRAMES];
  logic [FRAME_BITS:0]     pmap_mem [1 << PMAP_ABITS];
  logic [7:0]              ram_mem  [1 << ADDR_BITS];
  logic [ADDR_BITS-1:0]    brk_q    [MAX_PROCS];

  // request and walk registers
  logic [1:0]              act_q;
  logic [PID_BITS-1:0]     pid_q;
  logic [SIZE_BITS-1:0]    size_q;
  logic [ADDR_BITS-1:0]    va_q;
  logic [7:0]              wd_q;
  logic [PAGES_BITS-1:0]   pages_q;
  logic [ADDR_BITS-1:0]    bp_q, bp_start_q;
  logic [FRAME_BITS-1:0]   f_q, scan_q, prev_q;
  logic                    scan_v_q;
  logic [CNT_BITS-1:0]     got_q, free_cnt_q;
  logic [ADDR_BITS-1:0]    clr_q;

  logic [PID_BITS-1:0]     own_rd_q;
  logic [FRAME_BITS-1:0]   pos_rd_q;
  logic [FRAME_BITS:0]     next_rd_q, pmap_rd_q;
  logic [7:0]              ram_rd_q;

  logic                    out_valid_q, status_q;
  logic [ADDR_BITS-1:0]    region_q;
  logic [7:0]              rdata_q;

  logic [PIDX_BITS-1:0]    pidx;
  logic [PAGES_BITS-1:0]   pages_in;
  logic [ADDR_BITS+2:0]    brk_end;
  logic [FRAME_BITS-1:0]   fa;
  logic                    scan_hit;

  logic                    own_we, pos_we, next_we, pmap_we, ram_we;
  logic [FRAME_BITS-1:0]   own_wa, own_ra, pos_wa, next_wa, fr_ra;
  logic [PID_BITS-1:0]     own_wd;
  logic [FRAME_BITS-1:0]   pos_wd;
  logic [FRAME_BITS:0]     next_wd, pmap_wd;
  logic [PMAP_ABITS-1:0]   pmap_wa, pmap_ra;
  logic [ADDR_BITS-1:0]    ram_wa, ram_ra;
  logic [7:0]              ram_wd;

  assign pidx     = pid_q[PIDX_BITS-1:0] - PIDX_BITS'(1);
  assign pages_in = PAGES_BITS'(({1'b0, alloc_size_i} + 22'd1023) >> OFFSET_BITS);
  assign brk_end  = {3'b000, bp_start_q} + {1'b0, pages_q, {OFFSET_BITS{1'b0}}};
  assign fa       = scan_q - FRAME_BITS'(1);
  assign scan_hit = (cmd_i.op == OP_SCAN) && scan_v_q && (own_rd_q == '0)
                    && ({1'b0, got_q} != pages_q);

  assign sts_o.clr_last  = &clr_q;
  assign sts_o.action    = act_q;
  assign sts_o.pid_ok    = (pid_q != '0) && (pid_q <= PID_BITS'(MAX_PROCS));
  assign sts_o.alloc_ok  = (size_q != '0) && (pages_q <= PAGES_BITS'(NUM_FRAMES))
                           && (pages_q <= {1'b0, free_cnt_q})
                           && (brk_end < (23'd1 << ADDR_BITS));
  assign sts_o.map_ok    = pmap_rd_q[FRAME_BITS];
  assign sts_o.own_ok    = (own_rd_q == pid_q);
  assign sts_o.pos_zero  = (pos_rd_q == '0);
  assign sts_o.next_last = next_rd_q[FRAME_BITS];
  assign sts_o.scan_full = ({1'b0, got_q} == pages_q);
  assign sts_o.out_busy  = out_valid_q && out_stall_i;

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign region_address_o = region_q;
  assign read_data_o      = rdata_q;

  // memory port steering
  always_comb begin
    own_we  = 1'b0;  own_wa  = fa;       own_wd  = pid_q;
    pos_we  = 1'b0;  pos_wa  = fa;       pos_wd  = got_q[FRAME_BITS-1:0];
    next_we = 1'b0;  next_wa = prev_q;   next_wd = {1'b0, fa};
    pmap_we = 1'b0;  pmap_wa = {pidx, bp_q[ADDR_BITS-1 -: VPAGE_BITS]};
    pmap_wd = {1'b1, fa};
    ram_we  = 1'b0;  ram_wa  = {f_q, va_q[OFFSET_BITS-1:0]};  ram_wd = wd_q;
    own_ra  = (cmd_i.op == OP_SCAN) ? scan_q : pmap_rd_q[FRAME_BITS-1:0];
    fr_ra   = (cmd_i.op == OP_FRAME_RD) ? pmap_rd_q[FRAME_BITS-1:0] :
              (cmd_i.op == OP_WALK) ? next_rd_q[FRAME_BITS-1:0] : f_q;
    pmap_ra = {pidx, va_q[ADDR_BITS-1 -: VPAGE_BITS]};
    ram_ra  = {f_q, va_q[OFFSET_BITS-1:0]};
    case (cmd_i.op)
      OP_CLEAR: begin
        own_we  = 1'b1; own_wa  = clr_q[FRAME_BITS-1:0]; own_wd  = '0;
        pmap_we = 1'b1; pmap_wa = clr_q[PMAP_ABITS-1:0]; pmap_wd = '0;
        ram_we  = 1'b1; ram_wa  = clr_q;                 ram_wd  = '0;
      end
      OP_SCAN: begin
        own_we  = scan_hit;
        pos_we  = scan_hit;
        pmap_we = scan_hit;
        next_we = scan_hit && (got_q != '0);
      end
      OP_ALLOC_END: begin
        next_we = 1'b1;
        next_wd = {1'b1, {FRAME_BITS{1'b0}}};
      end
      OP_WALK: begin
        own_we = 1'b1; own_wa = f_q; own_wd = '0;
      end
      OP_RAM_WR: ram_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (own_we)  own_mem[own_wa]   <= own_wd;
    if (pos_we)  pos_mem[pos_wa]   <= pos_wd;
    if (next_we) next_mem[next_wa] <= next_wd;
    if (pmap_we) pmap_mem[pmap_wa] <= pmap_wd;
    if (ram_we)  ram_mem[ram_wa]   <= ram_wd;
    own_rd_q  <= own_mem[own_ra];
    pos_rd_q  <= pos_mem[fr_ra];
    next_rd_q <= next_mem[fr_ra];
    pmap_rd_q <= pmap_mem[pmap_ra];
    ram_rd_q  <= ram_mem[ram_ra];
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LATCH: begin
        act_q   <= action_i;
        pid_q   <= process_id_i;
        size_q  <= alloc_size_i;
        va_q    <= virtual_address_i;
        wd_q    <= write_data_i;
        pages_q <= pages_in;
      end
      OP_FRAME_RD: f_q <= pmap_rd_q[FRAME_BITS-1:0];
      OP_WALK:     f_q <= next_rd_q[FRAME_BITS-1:0];
      OP_SCAN_INIT: begin
        bp_q <= bp_start_q;
      end
      OP_SCAN: begin
        if (scan_hit) begin
          prev_q <= fa;
          bp_q   <= bp_q + ADDR_BITS'(1 << OFFSET_BITS);
        end
      end
      default: ;
    endcase
    if (cmd_i.op == OP_RESULT) begin
      status_q <= !cmd_i.ok;
      region_q <= (cmd_i.ok && act_q == ACT_ALLOC) ? bp_start_q : '0;
      rdata_q  <= (cmd_i.ok && act_q == ACT_READ) ? ram_rd_q : '0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      scan_q      <= '0;
      scan_v_q    <= 1'b0;
      got_q       <= '0;
      free_cnt_q  <= CNT_BITS'(NUM_FRAMES);
      out_valid_q <= 1'b0;
      bp_start_q  <= '0;
      for (int i = 0; i < MAX_PROCS; i++) brk_q[i] <= BREAK_RESET;
    end else begin
      if (cmd_i.op == OP_CLEAR) clr_q <= clr_q + ADDR_BITS'(1);
      if (cmd_i.op == OP_LATCH) bp_start_q <= brk_q[process_id_i[PIDX_BITS-1:0]
                                                     - PIDX_BITS'(1)];
      if (cmd_i.op == OP_SCAN_INIT) begin
        scan_q   <= '0;
        scan_v_q <= 1'b0;
        got_q    <= '0;
      end else if (cmd_i.op == OP_SCAN) begin
        scan_q   <= scan_q + FRAME_BITS'(1);
        scan_v_q <= 1'b1;
        if (scan_hit) got_q <= got_q + CNT_BITS'(1);
      end
      if (cmd_i.op == OP_ALLOC_END) begin
        free_cnt_q  <= free_cnt_q - pages_q[CNT_BITS-1:0];
        brk_q[pidx] <= bp_q;
      end
      if (cmd_i.op == OP_WALK) free_cnt_q <= free_cnt_q + CNT_BITS'(1);
      if (cfg_we_i) begin
        for (int i = 0; i < MAX_PROCS; i++) brk_q[i] <= cfg_data_i;
      end
      if (cmd_i.op == OP_RESULT) out_valid_q <= 1'b1;
      else if (!out_stall_i)     out_valid_q <= 1'b0;
    end
  end

endmodule

[rtl/paged_memory_allocator_mmu.sv]
// ----------------------------------------------------------------------------
// paged_memory_allocator_mmu
// Paged allocator and byte translator for up to eight processes: allocate,
// free, read byte and write byte requests, one result per request.
// ----------------------------------------------------------------------------
//  channel   direction  handshake               payload
//  in        input      in_valid_i/in_stall_o   action, process_id, alloc_size,
//                                               virtual_address, write_data
//  out       output     out_valid_o/out_stall_i status, region_address, read_data
//  cfg       input      cfg_valid_i/cfg_ready_o initial_break
//
// After reset the block sweeps its byte memory, frame owners and page maps
// one entry per cycle, with in_stall_o high (cfg is taken).
// Each request holds in_stall_o high until its result is handed off. Free
// walks the frame chain; the length of an allocate is set by the
// one-frame-per-cycle scan of the owner table. A refused allocate or a bad
// process id goes straight to the result. One request is in flight at a time;
// a new one is taken while the previous result still waits under out_stall_i.
module paged_memory_allocator_mmu import pma_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           action_i,
  input  logic [PID_BITS-1:0]  process_id_i,
  input  logic [SIZE_BITS-1:0] alloc_size_i,
  input  logic [ADDR_BITS-1:0] virtual_address_i,
  input  logic [7:0]           write_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 status_o,
  output logic [ADDR_BITS-1:0] region_address_o,
  output logic [7:0]           read_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [ADDR_BITS-1:0] initial_break_i
);

  cmd_t cmd;
  sts_t sts;

  // configuration writes land at once: reload every break pointer
  assign cfg_ready_o = 1'b1;

  pma_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pma_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .action_i          (action_i),
    .process_id_i      (process_id_i),
    .alloc_size_i      (alloc_size_i),
    .virtual_address_i (virtual_address_i),
    .write_data_i      (write_data_i),
    .cfg_we_i          (cfg_valid_i),
    .cfg_data_i        (initial_break_i),
    .out_stall_i       (out_stall_i),
    .out_valid_o       (out_valid_o),
    .status_o          (status_o),
    .region_address_o  (region_address_o),
    .read_data_o       (read_data_o)
  );

endmodule

[dv/pma_checker.sv]
// ----------------------------------------------------------------------------
// pma_checker
// Watches the request, result and break-register channels of the paged
// allocator, keeps its own copy of frames, page maps, breaks and byte memory,
// and compares every result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module pma_checker import pma_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic [1:0]           action_i,
  input  logic [PID_BITS-1:0]  process_id_i,
  input  logic [SIZE_BITS-1:0] alloc_size_i,
  input  logic [ADDR_BITS-1:0] virtual_address_i,
  input  logic [7:0]           write_data_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic                 status_i,
  input  logic [ADDR_BITS-1:0] region_address_i,
  input  logic [7:0]           read_data_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [ADDR_BITS-1:0] initial_break_i,
  output int                   fail_count_o,
  output int                   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VPAGES = 1 << VPAGE_BITS;
  localparam int PAGE_BYTES = 1 << OFFSET_BITS;
  localparam longint RAM_BYTES = longint'(NUM_FRAMES) << OFFSET_BITS;

  typedef struct {
    logic                 status;
    logic [ADDR_BITS-1:0] region;
    logic [7:0]           rdata;
  } reply_t;

  logic [PID_BITS-1:0]  frame_owner [NUM_FRAMES];
  int                   frame_pos [NUM_FRAMES];
  int                   frame_link [NUM_FRAMES];   // -1 marks the chain tail
  logic                 map_live [MAX_PROCS][VPAGES];
  int                   map_frame [MAX_PROCS][VPAGES];
  logic [ADDR_BITS-1:0] proc_break [MAX_PROCS];
  byte unsigned         phys_mem [int];
  reply_t               replies_due [$];
  int                   fails = 0;

  assign fail_count_o = fails;

  initial begin
    pending_o = 0;
    for (int f = 0; f < NUM_FRAMES; f++) begin
      frame_owner[f] = '0;
      frame_pos[f]   = 0;
      frame_link[f]  = -1;
    end
    for (int p = 0; p < MAX_PROCS; p++) begin
      proc_break[p] = BREAK_RESET;
      for (int v = 0; v < VPAGES; v++) begin
        map_live[p][v]  = 1'b0;
        map_frame[p][v] = 0;
      end
    end
  end

  function automatic logic translate(int pid, logic [ADDR_BITS-1:0] va, output int pa);
    int vp;
    int f;
    vp = int'(va >> OFFSET_BITS) & (VPAGES - 1);
    pa = 0;
    if (!map_live[pid-1][vp]) return 1'b0;
    f = map_frame[pid-1][vp];
    if (frame_owner[f] != pid) return 1'b0;
    pa = (f << OFFSET_BITS) | int'(va[OFFSET_BITS-1:0]);
    return 1'b1;
  endfunction

  function automatic logic grant_pages(int pid, logic [SIZE_BITS-1:0] size,
                                       output logic [ADDR_BITS-1:0] region);
    longint pages;
    int picks[$];
    logic [ADDR_BITS-1:0] bp;
    region = '0;
    bp = proc_break[pid-1];
    if (size == 0) return 1'b0;
    pages = (longint'(size) + PAGE_BYTES - 1) >> OFFSET_BITS;
    if (pages > NUM_FRAMES) return 1'b0;
    for (int f = 0; f < NUM_FRAMES && picks.size() < pages; f++)
      if (frame_owner[f] == 0) picks.push_back(f);
    if (picks.size() < pages) return 1'b0;
    if (longint'(bp) + pages * PAGE_BYTES >= RAM_BYTES) return 1'b0;
    region = bp;
    for (int i = 0; i < pages; i++) begin
      frame_owner[picks[i]] = PID_BITS'(pid);
      frame_pos[picks[i]]   = i;
      frame_link[picks[i]]  = (i + 1 < pages) ? picks[i+1] : -1;
      map_live[pid-1][int'(bp >> OFFSET_BITS)]  = 1'b1;
      map_frame[pid-1][int'(bp >> OFFSET_BITS)] = picks[i];
      bp = bp + ADDR_BITS'(PAGE_BYTES);
    end
    proc_break[pid-1] = bp;
    return 1'b1;
  endfunction

  function automatic logic release_chain(int pid, logic [ADDR_BITS-1:0] va);
    int vp;
    int f;
    int n;
    vp = int'(va >> OFFSET_BITS) & (VPAGES - 1);
    if (!map_live[pid-1][vp]) return 1'b0;
    f = map_frame[pid-1][vp];
    if (frame_pos[f] != 0 || frame_owner[f] != pid) return 1'b0;
    for (int steps = 0; steps < NUM_FRAMES; steps++) begin
      n = frame_link[f];
      frame_owner[f] = '0;
      if (n < 0 || n >= NUM_FRAMES) break;
      f = n;
    end
    return 1'b1;
  endfunction

  function automatic reply_t serve(logic [1:0] act, int pid, logic [SIZE_BITS-1:0] size,
                                   logic [ADDR_BITS-1:0] va, logic [7:0] wd);
    reply_t r;
    logic ok;
    int pa;
    r.region = '0;
    r.rdata  = '0;
    ok = 1'b0;
    if (pid >= 1 && pid <= MAX_PROCS) begin
      case (act)
        ACT_ALLOC: ok = grant_pages(pid, size, r.region);
        ACT_FREE:  ok = release_chain(pid, va);
        ACT_READ: begin
          ok = translate(pid, va, pa);
          if (ok) r.rdata = phys_mem.exists(pa) ? phys_mem[pa] : 8'd0;
        end
        default: begin
          ok = translate(pid, va, pa);
          if (ok) phys_mem[pa] = wd;
        end
      endcase
    end
    r.status = !ok;
    return r;
  endfunction

  // Sample at the falling edge: everything is settled, and the flags tell
  // what the next rising edge accepts.
  always @(negedge clk_i) begin
    reply_t want;
    if (rst_ni) begin
      // Retire the result first: it can never belong to a request taken now.
      if (out_valid_i && !out_stall_i) begin
        if (replies_due.size() == 0) begin
          fails++;
          if (fails <= 10) $display("[%0t] result with nothing outstanding", $realtime);
        end else begin
          want = replies_due.pop_front();
          if (want.status !== status_i || want.region !== region_address_i ||
              want.rdata !== read_data_i) begin
            fails++;
            if (fails <= 10)
              $display("[%0t] mismatch: expected st=%0d reg=%h rd=%h, got st=%0d reg=%h rd=%h",
                       $realtime, want.status, want.region, want.rdata,
                       status_i, region_address_i, read_data_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        replies_due.push_back(serve(action_i, int'(process_id_i), alloc_size_i,
                                    virtual_address_i, write_data_i));
      if (cfg_valid_i && cfg_ready_i) begin
        for (int p = 0; p < MAX_PROCS; p++) proc_break[p] = initial_break_i;
      end
    end
    pending_o = replies_due.size();
  end
endmodule

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives the paged allocator with a directed opening and then phases of
// random allocate/free/read/write traffic under several break settings,
// with random gaps and stalls; the checker judges every result.
// ----------------------------------------------------------------------------
module testbench import pma_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // The post-reset sweep alone is quiet; allow several times its length.
  localparam int QUIET_LIMIT = 4_000_000;
  localparam int PHASE_ITEMS = 112;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           action = ACT_READ;
  logic [PID_BITS-1:0]  pid = '0;
  logic [SIZE_BITS-1:0] size = '0;
  logic [ADDR_BITS-1:0] vaddr = '0;
  logic [7:0]           wdata = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b1;
  logic                 status;
  logic [ADDR_BITS-1:0] region;
  logic [7:0]           rdata;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [ADDR_BITS-1:0] cfg_break = '0;
  int                   fail_count;
  int                   pending;

  typedef struct {
    logic [1:0]          act;
    logic [PID_BITS-1:0] who;
  } issued_t;

  typedef struct {
    logic [PID_BITS-1:0]  who;
    logic [ADDR_BITS-1:0] base;
    int                   pages;
  } block_t;

  issued_t in_flight [$];
  block_t  live_blocks [$];
  logic    send_burst = 1'b0;   // no gaps on the request side
  logic    drain_burst = 1'b0;  // no stalls on the result side
  int      sent = 0;
  int      results = 0;
  int      grants = 0;
  int      faults = 0;
  int      quiet = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  paged_memory_allocator_mmu uut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .action_i(action), .process_id_i(pid), .alloc_size_i(size),
    .virtual_address_i(vaddr), .write_data_i(wdata),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .status_o(status), .region_address_o(region), .read_data_o(rdata),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .initial_break_i(cfg_break)
  );

  pma_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .action_i(action), .process_id_i(pid), .alloc_size_i(size),
    .virtual_address_i(vaddr), .write_data_i(wdata),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .status_i(status), .region_address_i(region), .read_data_i(rdata),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready), .initial_break_i(cfg_break),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Watchdog: end the run after too long without any handshake.
  always @(negedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", quiet);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result side: stall a random number of cycles per item, then take it.
  // Successful allocations are remembered so later traffic can hit them.
  // Sample the payload before the accepting edge: a new result may load there.
  initial begin
    issued_t              req;
    block_t               blk;
    int                   hold;
    logic                 take;
    logic                 seen_status;
    logic [ADDR_BITS-1:0] seen_region;
    forever begin
      hold = drain_burst ? 0 : $urandom_range(0, 5);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do begin
        @(negedge clk);
        take        = out_valid;
        seen_status = status;
        seen_region = region;
        @(posedge clk);
      end while (!take);
      results++;
      req = in_flight.pop_front();
      if (seen_status) faults++;
      if (req.act == ACT_ALLOC && !seen_status) begin
        grants++;
        blk.who   = req.who;
        blk.base  = seen_region;
        blk.pages = 1;
        live_blocks.push_back(blk);
      end
    end
  end

  // Hold the item until the edge that takes it; keep valid high across
  // back-to-back items so it only changes once per edge.
  task automatic issue(logic [1:0] act, logic [PID_BITS-1:0] who,
                       logic [SIZE_BITS-1:0] bytes, logic [ADDR_BITS-1:0] va,
                       logic [7:0] wd);
    int      gap;
    logic    take;
    issued_t req;
    gap = send_burst ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    pid      <= who;
    size     <= bytes;
    vaddr    <= va;
    wdata    <= wd;
    do begin
      @(negedge clk);
      take = !in_stall;
      @(posedge clk);
    end while (!take);
    req.act = act;
    req.who = who;
    in_flight.push_back(req);
    sent++;
  endtask

  // Drain, wait out the tail of the last request, then write the break.
  task automatic set_break(logic [ADDR_BITS-1:0] value);
    logic take;
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_break <= value;
    do begin
      @(negedge clk);
      take = cfg_ready;
      @(posedge clk);
    end while (!take);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_request();
    int                   roll;
    int                   pick;
    block_t               blk;
    logic [PID_BITS-1:0]  who;
    logic [SIZE_BITS-1:0] bytes;
    logic [ADDR_BITS-1:0] va;
    roll  = $urandom_range(0, 99);
    who   = PID_BITS'($urandom_range(1, MAX_PROCS));
    va    = ADDR_BITS'($urandom());
    bytes = SIZE_BITS'($urandom_range(1, 3 * 1024));
    if (roll < 30) begin
      case ($urandom_range(0, 9))
        0, 1:    bytes = SIZE_BITS'(1024 * $urandom_range(1, 4));
        2:       bytes = SIZE_BITS'($urandom_range(1, 64 * 1024));
        3:       bytes = SIZE_BITS'($urandom());
        default: ;
      endcase
      issue(ACT_ALLOC, who, bytes, va, 8'($urandom()));
    end else if (roll < 45) begin
      if (live_blocks.size() > 0 && $urandom_range(0, 9) != 0) begin
        pick = $urandom_range(0, live_blocks.size() - 1);
        blk  = live_blocks[pick];
        live_blocks.delete(pick);
        va = blk.base + ADDR_BITS'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : 0);
        who = ($urandom_range(0, 9) == 0) ? who : blk.who;
      end
      issue(ACT_FREE, who, bytes, va, 8'($urandom()));
    end else if (roll < 95) begin
      if (live_blocks.size() > 0 && $urandom_range(0, 9) != 0) begin
        blk = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
        va  = blk.base + ADDR_BITS'($urandom_range(0, 1023));
        who = ($urandom_range(0, 9) == 0) ? who : blk.who;
      end
      issue(roll < 70 ? ACT_READ : ACT_WRITE, who, bytes, va, 8'($urandom()));
    end else begin
      // Noise: any action, always with a process id outside the valid range.
      who = PID_BITS'(($urandom_range(0, 1) == 0) ? 0 : $urandom_range(MAX_PROCS + 1, 15));
      issue(2'($urandom_range(0, 3)), who, SIZE_BITS'($urandom()), ADDR_BITS'($urandom()),
            8'($urandom()));
    end
  endtask

  initial begin
    logic [ADDR_BITS-1:0] settings [5];
    settings[0] = 20'h00000;
    settings[1] = 20'hFFFFF;
    settings[2] = 20'hFFC00;
    settings[3] = ADDR_BITS'($urandom_range(1, 20'h7FFFF));
    settings[4] = BREAK_RESET;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening under the reset break.
    issue(ACT_ALLOC, 4'd0, 21'd1024, 20'h0, 8'h0);          // reserved id
    issue(ACT_READ, 4'd9, 21'd0, 20'h00400, 8'h0);          // id above range
    issue(ACT_ALLOC, 4'd1, 21'd0, 20'h0, 8'h0);             // zero bytes
    issue(ACT_ALLOC, 4'd1, 21'd1, 20'h0, 8'h0);             // one page at 0x00400
    issue(ACT_WRITE, 4'd1, 21'd0, 20'h00400, 8'hFF);
    issue(ACT_WRITE, 4'd1, 21'd0, 20'h007FF, 8'hA5);
    issue(ACT_READ, 4'd1, 21'd0, 20'h00400, 8'h0);
    issue(ACT_READ, 4'd1, 21'd0, 20'h007FF, 8'h0);
    issue(ACT_READ, 4'd2, 21'd0, 20'h00400, 8'h0);          // foreign page
    issue(ACT_WRITE, 4'd1, 21'd0, 20'hFFFFF, 8'h00);        // unmapped page
    issue(ACT_ALLOC, 4'd1, 21'd3000, 20'h0, 8'h0);          // three pages at 0x00800
    issue(ACT_FREE, 4'd1, 21'd0, 20'h00C00, 8'h0);          // not the chain head
    issue(ACT_FREE, 4'd3, 21'd0, 20'h00800, 8'h0);          // unmapped for caller
    issue(ACT_FREE, 4'd1, 21'd0, 20'h00801, 8'h0);          // head, inside the page
    issue(ACT_READ, 4'd1, 21'd0, 20'h00C00, 8'h0);          // stale after free
    issue(ACT_FREE, 4'd1, 21'd0, 20'h00800, 8'h0);          // already freed
    issue(ACT_ALLOC, 4'd2, 21'h100000, 20'h0, 8'h0);        // more than free frames
    issue(ACT_ALLOC, 4'd2, 21'h1FFFFF, 20'h0, 8'h0);        // more than all frames
    issue(ACT_ALLOC, 4'd3, 21'd1047552, 20'h0, 8'h0);       // break reaches RAM size
    issue(ACT_ALLOC, 4'd8, 21'd1024, 20'h0, 8'h0);
    issue(ACT_READ, 4'd8, 21'd0, 20'h00400, 8'h0);
    issue(ACT_READ, 4'd1, 21'd0, 20'h00400, 8'h0);

    foreach (settings[s]) begin
      set_break(settings[s]);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 28 == 0) begin
          send_burst  = ($urandom_range(0, 3) == 0);
          drain_burst = ($urandom_range(0, 3) == 0);
        end
        random_request();
      end
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Covered %0d requests over 5 break settings: %0d results, %0d allocations",
             sent, results, grants);
    $display("granted, %0d refusals or faults; %0d mismatches.", faults, fail_count);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
